// File: hw/rtl/assert_macros.svh
// Assertion helpers used by density_to_velocity_grid.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// File: hw/rtl/dvg_pkg.sv
`default_nettype none
package dvg_pkg;
	localparam int MAX_COLUMNS   = 1024;
	localparam int MAX_ROWS      = 1024;
	localparam int DENSITY_BITS  = 24;
	localparam int FRACTION_BITS = 16;
	localparam int VEL_BITS      = FRACTION_BITS + 4;
	localparam int COORD_BITS    = 11;
	localparam int ADDR_BITS     = $clog2(MAX_ROWS);
	localparam int SUM_BITS      = DENSITY_BITS + 3;
	localparam int NUM_BITS      = DENSITY_BITS + 4;
	localparam int MAG_BITS      = DENSITY_BITS + 3;
	localparam int DEN_BITS      = DENSITY_BITS + 2;
	localparam int QUO_BITS      = VEL_BITS - 1;
	localparam int CFG_IDX_BITS  = 1;

	typedef logic signed [DENSITY_BITS-1:0] density_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [VEL_BITS-1:0] velocity_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_GRID_COLUMNS = 1'd0;
	localparam cfg_idx_t REG_GRID_ROWS    = 1'd1;
	localparam coord_t GRID_RESET = 11'd256;
endpackage
`default_nettype wire

// File: hw/rtl/dvg_if.sv
`default_nettype none
interface dvg_in_if;
	import dvg_pkg::*;
	logic     valid;
	logic     ready;
	density_t density;
	modport source (output valid, output density, input ready);
	modport sink (input valid, input density, output ready);
endinterface

interface dvg_out_if;
	import dvg_pkg::*;
	logic      valid;
	logic      ready;
	coord_t    point_x;
	coord_t    point_y;
	velocity_t velocity_x;
	velocity_t velocity_y;
	logic      zero_divisor;
	logic      last_of_run;
	modport source (output valid, output point_x, output point_y, output velocity_x,
		output velocity_y, output zero_divisor, output last_of_run, input ready);
	modport sink (input valid, input point_x, input point_y, input velocity_x,
		input velocity_y, input zero_divisor, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/density_to_velocity_grid.sv
// An accepted item passes ST_READ, ST_SETUP and ST_DIV before its first result in ST_OUT;
// each further point runs ST_SETUP and ST_DIV again. An item gives one point inside the grid,
// up to four at a corner; the two bit-serial dividers make one quotient bit per cycle each.
// One item is in work at a time; the next is taken after its last result is delivered.
// Reset clears position, prior cells and sizes (256 x 256); the line store is not cleared.
`default_nettype none
`include "assert_macros.svh"
module density_to_velocity_grid (
	input  wire                     clk,
	input  wire                     arst_n,
	dvg_in_if.sink                  in_item,
	dvg_out_if.source               out_item,
	input  wire                     cfg_we,
	input  wire dvg_pkg::cfg_idx_t  cfg_index,
	input  wire dvg_pkg::coord_t    cfg_data
);
	import dvg_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_SETUP, ST_DIV, ST_OUT} state_t;

	state_t state_q;
	coord_t grid_columns_q, grid_rows_q, column_index_q, row_index_q;
	density_t prior_same_q, prior_prior_q;
	density_t store_mem [MAX_ROWS];
	density_t rd_data_q;
	density_t r11_q, r10_q, r00_q, r01_q;
	coord_t cx_q, cy_q;
	logic nx_q, ny_q, pa_q, pb_q;
	logic [$clog2(QUO_BITS)-1:0] cnt_q;

	logic enx_q, eny_q, zero_q, negx_q, negy_q, satx_q, saty_q;
	logic [DEN_BITS-1:0] md_q;
	logic [DEN_BITS-1:0] remx_q, remy_q;
	logic [QUO_BITS-1:0] ddx_q, ddy_q, qx_q, qy_q;

	coord_t cols, rows, cx, cy, px, py;
	logic xin, yin, accept;
	logic signed [SUM_BITS-1:0] den_c, dx_c, dy_c;
	logic signed [NUM_BITS-1:0] numx_c, numy_c;
	logic [MAG_BITS-1:0] mnx_c, mny_c;
	logic [DEN_BITS-1:0] md_c;
	logic [DEN_BITS:0] trialx, trialy;
	logic last_pt;

	function automatic coord_t clamp_size(coord_t v, coord_t hi);
		coord_t r;
		r = v;
		if (v < 11'd2) r = 11'd2;
		else if (v > hi) r = hi;
		return r;
	endfunction

	function automatic velocity_t finish(logic en, logic zero, logic sat, logic neg,
		logic [QUO_BITS-1:0] q);
		velocity_t v;
		v = '0;
		if (en && !zero) begin
			if (sat) v = neg ? velocity_t'({1'b1, {QUO_BITS{1'b0}}})
				: velocity_t'({1'b0, {QUO_BITS{1'b1}}});
			else v = neg ? -velocity_t'({1'b0, q}) : velocity_t'({1'b0, q});
		end
		return v;
	endfunction

	assign cols = clamp_size(grid_columns_q, coord_t'(MAX_COLUMNS));
	assign rows = clamp_size(grid_rows_q, coord_t'(MAX_ROWS));
	assign cx = (column_index_q >= cols) ? cols - 11'd1 : column_index_q;
	assign cy = (row_index_q >= rows) ? rows - 11'd1 : row_index_q;
	assign accept = in_item.valid && in_item.ready;
	assign in_item.ready = (state_q == ST_IDLE) && !cfg_we;

	assign px = pa_q ? cols : cx_q;
	assign py = pb_q ? rows : cy_q;
	assign xin = (px != '0) && (px != cols);
	assign yin = (py != '0) && (py != rows);

	always_comb begin
		den_c = '0;
		dx_c = '0;
		dy_c = '0;
		if (xin && yin) begin
			den_c = SUM_BITS'(r10_q) + SUM_BITS'(r00_q) + SUM_BITS'(r11_q) + SUM_BITS'(r01_q);
			dx_c = SUM_BITS'(r10_q) - SUM_BITS'(r00_q) + SUM_BITS'(r11_q) - SUM_BITS'(r01_q);
			dy_c = SUM_BITS'(r01_q) - SUM_BITS'(r00_q) + SUM_BITS'(r11_q) - SUM_BITS'(r10_q);
		end else if (xin) begin
			den_c = SUM_BITS'(r11_q) + SUM_BITS'(r01_q);
			dx_c = SUM_BITS'(r11_q) - SUM_BITS'(r01_q);
		end else if (yin) begin
			den_c = SUM_BITS'(r11_q) + SUM_BITS'(r10_q);
			dy_c = SUM_BITS'(r11_q) - SUM_BITS'(r10_q);
		end
		numx_c = -(NUM_BITS'(dx_c) <<< 1);
		numy_c = -(NUM_BITS'(dy_c) <<< 1);
		mnx_c = numx_c[NUM_BITS-1] ? MAG_BITS'(-numx_c) : MAG_BITS'(numx_c);
		mny_c = numy_c[NUM_BITS-1] ? MAG_BITS'(-numy_c) : MAG_BITS'(numy_c);
		md_c = den_c[SUM_BITS-1] ? DEN_BITS'(-den_c) : DEN_BITS'(den_c);
		trialx = {remx_q, ddx_q[QUO_BITS-1]};
		trialy = {remy_q, ddy_q[QUO_BITS-1]};
	end

	assign last_pt = (pa_q == nx_q) && (pb_q == ny_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grid_columns_q <= GRID_RESET;
			grid_rows_q <= GRID_RESET;
			column_index_q <= '0;
			row_index_q <= '0;
			prior_same_q <= '0;
			prior_prior_q <= '0;
			pa_q <= 1'b0;
			pb_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_COLUMNS: grid_columns_q <= cfg_data;
					REG_GRID_ROWS: grid_rows_q <= cfg_data;
					default: ;
				endcase
				column_index_q <= '0;
				row_index_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cx_q <= cx;
						cy_q <= cy;
						nx_q <= (cx == cols - 11'd1);
						ny_q <= (cy == rows - 11'd1);
						pa_q <= 1'b0;
						pb_q <= 1'b0;
						r11_q <= in_item.density;
						r10_q <= prior_same_q;
						r00_q <= prior_prior_q;
						prior_same_q <= in_item.density;
						if (cy + 11'd1 < rows) begin
							row_index_q <= cy + 11'd1;
							column_index_q <= cx;
						end else begin
							row_index_q <= '0;
							column_index_q <= (cx + 11'd1 < cols) ? cx + 11'd1 : '0;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					r01_q <= rd_data_q;
					prior_prior_q <= rd_data_q;
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					enx_q <= xin;
					eny_q <= yin;
					zero_q <= (xin || yin) && (md_c == '0);
					md_q <= md_c;
					negx_q <= numx_c[NUM_BITS-1] != den_c[SUM_BITS-1];
					negy_q <= numy_c[NUM_BITS-1] != den_c[SUM_BITS-1];
					satx_q <= {2'b0, mnx_c} >= {md_c, 3'b0};
					saty_q <= {2'b0, mny_c} >= {md_c, 3'b0};
					remx_q <= DEN_BITS'(mnx_c >> 3);
					remy_q <= DEN_BITS'(mny_c >> 3);
					ddx_q <= {mnx_c[2:0], {FRACTION_BITS{1'b0}}};
					ddy_q <= {mny_c[2:0], {FRACTION_BITS{1'b0}}};
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (trialx >= {1'b0, md_q}) begin
						remx_q <= DEN_BITS'(trialx - {1'b0, md_q});
						qx_q <= {qx_q[QUO_BITS-2:0], 1'b1};
					end else begin
						remx_q <= trialx[DEN_BITS-1:0];
						qx_q <= {qx_q[QUO_BITS-2:0], 1'b0};
					end
					if (trialy >= {1'b0, md_q}) begin
						remy_q <= DEN_BITS'(trialy - {1'b0, md_q});
						qy_q <= {qy_q[QUO_BITS-2:0], 1'b1};
					end else begin
						remy_q <= trialy[DEN_BITS-1:0];
						qy_q <= {qy_q[QUO_BITS-2:0], 1'b0};
					end
					ddx_q <= ddx_q << 1;
					ddy_q <= ddy_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ($clog2(QUO_BITS))'(QUO_BITS - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_item.ready) begin
						if (last_pt) begin
							state_q <= ST_IDLE;
						end else begin
							if (pb_q != ny_q) begin
								pb_q <= 1'b1;
							end else begin
								pb_q <= 1'b0;
								pa_q <= 1'b1;
							end
							state_q <= ST_SETUP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rd_data_q <= store_mem[cy[ADDR_BITS-1:0]];
		if (state_q == ST_READ) store_mem[cy_q[ADDR_BITS-1:0]] <= r11_q;
	end

	assign out_item.valid = (state_q == ST_OUT);
	assign out_item.point_x = px;
	assign out_item.point_y = py;
	assign out_item.velocity_x = finish(enx_q, zero_q, satx_q, negx_q, qx_q);
	assign out_item.velocity_y = finish(eny_q, zero_q, saty_q, negy_q, qy_q);
	assign out_item.zero_divisor = zero_q;
	assign out_item.last_of_run = last_pt;

	`ASSERT_NEVER(a_zero_vel, clk, arst_n, out_item.valid && out_item.zero_divisor && (out_item.velocity_x != '0 || out_item.velocity_y != '0), "velocity with zero divisor")
	`ASSERT_NEVER(a_one_side, clk, arst_n, in_item.ready && out_item.valid, "input taken while result pending")
	`ASSERT_ALWAYS(a_corner, clk, arst_n, !(out_item.valid && !xin && !yin) || (out_item.velocity_x == '0 && out_item.velocity_y == '0 && !out_item.zero_divisor), "corner not zero")
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import dvg_pkg::*;

	typedef struct packed {
		coord_t    px;
		coord_t    py;
		velocity_t vx;
		velocity_t vy;
		logic      zd;
		logic      last;
	} grid_point_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	coord_t    cfg_data;

	dvg_in_if  in_if();
	dvg_out_if out_if();

	density_to_velocity_grid DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_if.sink),
		.out_item(out_if.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	grid_point_t expected_points[$];
	int          fail_count;
	bit          quiet;
	int          stall_left;

	coord_t      cols_reg;
	coord_t      rows_reg;
	density_t    line_store[MAX_ROWS];
	density_t    cell_above;
	density_t    cell_diag;
	int          col_pos;
	int          row_pos;
	density_t    last_density;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic int clamp_grid(input coord_t v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic velocity_t scaled_ratio(input longint diff, input longint sum,
		inout logic zd);
		longint num;
		longint mn;
		longint md;
		longint q;
		longint lim;
		bit neg;
		lim = longint'(1) << (VEL_BITS - 1);
		if (sum == 0) begin
			zd = 1'b1;
			return '0;
		end
		num = -2 * diff;
		neg = (num < 0) != (sum < 0);
		mn = num < 0 ? -num : num;
		md = sum < 0 ? -sum : sum;
		q = (mn << FRACTION_BITS) / md;
		if (neg) begin
			if (q > lim) q = lim;
			return velocity_t'(-q);
		end
		if (q > lim - 1) q = lim - 1;
		return velocity_t'(q);
	endfunction

	task automatic predict_points(input density_t d);
		int cols;
		int rows;
		int cx;
		int cy;
		int xs[2];
		int ys[2];
		int nx;
		int ny;
		longint r11;
		longint r01;
		longint r10;
		longint r00;
		grid_point_t p;
		bit xin;
		bit yin;
		cols = clamp_grid(cols_reg, MAX_COLUMNS);
		rows = clamp_grid(rows_reg, MAX_ROWS);
		cx = col_pos >= cols ? cols - 1 : col_pos;
		cy = row_pos >= rows ? rows - 1 : row_pos;
		r11 = d;
		r01 = line_store[cy];
		r10 = cell_above;
		r00 = cell_diag;
		xs[0] = cx;
		ys[0] = cy;
		nx = 1;
		ny = 1;
		if (cx == cols - 1) begin
			xs[1] = cols;
			nx = 2;
		end
		if (cy == rows - 1) begin
			ys[1] = rows;
			ny = 2;
		end
		for (int a = 0; a < nx; a++) begin
			for (int b = 0; b < ny; b++) begin
				p = '0;
				p.px = coord_t'(xs[a]);
				p.py = coord_t'(ys[b]);
				xin = xs[a] > 0 && xs[a] < cols;
				yin = ys[b] > 0 && ys[b] < rows;
				if (xin && yin) begin
					p.vx = scaled_ratio(r10 - r00 + r11 - r01, r10 + r00 + r11 + r01, p.zd);
					p.vy = scaled_ratio(r01 - r00 + r11 - r10, r10 + r00 + r11 + r01, p.zd);
				end else if (xin) begin
					p.vx = scaled_ratio(r11 - r01, r11 + r01, p.zd);
				end else if (yin) begin
					p.vy = scaled_ratio(r11 - r10, r11 + r10, p.zd);
				end
				p.last = (a == nx - 1) && (b == ny - 1);
				expected_points.push_back(p);
			end
		end
		line_store[cy] = d;
		cell_diag = density_t'(r01);
		cell_above = d;
		if (cy + 1 < rows) begin
			row_pos = cy + 1;
			col_pos = cx;
		end else begin
			row_pos = 0;
			col_pos = cx + 1 < cols ? cx + 1 : 0;
		end
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input coord_t value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRID_COLUMNS) cols_reg = value;
		else rows_reg = value;
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic set_grid(input coord_t c, input coord_t r);
		write_reg(REG_GRID_COLUMNS, c);
		write_reg(REG_GRID_ROWS, r);
	endtask

	task automatic send_cell(input density_t d);
		in_if.valid <= 1'b1;
		in_if.density <= d;
		do @(posedge clk); while (!in_if.ready);
		predict_points(d);
		last_density = d;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic density_t pick_density();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return -last_density;
			2: return density_t'(int'($urandom_range(0, 400)) - 200);
			3: return density_t'($urandom_range(1, 5000));
			default: return density_t'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_if.ready <= (stall_left == 1);
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			out_if.ready <= 1'b0;
			stall_left <= $urandom_range(1, 12);
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		grid_point_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point (%0d,%0d)",
					out_if.point_x, out_if.point_y));
			end else begin
				e = expected_points.pop_front();
				if (out_if.point_x !== e.px)
					report_mismatch($sformatf("point_x %0d, want %0d", out_if.point_x, e.px));
				if (out_if.point_y !== e.py)
					report_mismatch($sformatf("point_y %0d, want %0d", out_if.point_y, e.py));
				if (out_if.velocity_x !== e.vx)
					report_mismatch($sformatf("(%0d,%0d) velocity_x %0d, want %0d",
						e.px, e.py, out_if.velocity_x, e.vx));
				if (out_if.velocity_y !== e.vy)
					report_mismatch($sformatf("(%0d,%0d) velocity_y %0d, want %0d",
						e.px, e.py, out_if.velocity_y, e.vy));
				if (out_if.zero_divisor !== e.zd)
					report_mismatch($sformatf("(%0d,%0d) zero_divisor %b, want %b",
						e.px, e.py, out_if.zero_divisor, e.zd));
				if (out_if.last_of_run !== e.last)
					report_mismatch($sformatf("(%0d,%0d) last_of_run %b, want %b",
						e.px, e.py, out_if.last_of_run, e.last));
			end
		end
	end

	task automatic test_small_frame();
		set_grid(11'd2, 11'd2);
		send_cell(24'sd100);
		send_cell(24'sd300);
		send_cell(24'sd50);
		send_cell(24'sd7);
		send_cell(24'sd1);
		send_cell(24'sd2);
	endtask

	task automatic test_saturation_and_zero_sum();
		set_grid(11'd3, 11'd3);
		send_cell(density_t'(8388607));
		send_cell(density_t'(-8388608));
		send_cell(24'sd0);
		send_cell(24'sd0);
		send_cell(24'sd1);
		send_cell(-24'sd1);
		send_cell(24'sd5);
		send_cell(-24'sd5);
		send_cell(density_t'(8388607));
	endtask

	task automatic test_size_extremes();
		set_grid(11'd0, 11'd1);
		send_cell(24'sd9);
		send_cell(24'sd3);
		set_grid(11'd2047, 11'd2);
		repeat (3) send_cell(pick_density());
		set_grid(11'd2, 11'd1024);
		repeat (3) send_cell(pick_density());
	endtask

	task automatic test_random_frames();
		int sent;
		int cells;
		sent = 0;
		while (sent < 410) begin
			if ($urandom_range(0, 9) == 0)
				set_grid(coord_t'($urandom_range(0, 12)), coord_t'($urandom_range(0, 12)));
			else
				set_grid(coord_t'($urandom_range(2, 6)), coord_t'($urandom_range(2, 6)));
			cells = clamp_grid(cols_reg, MAX_COLUMNS) * clamp_grid(rows_reg, MAX_ROWS);
			cells = cells * $urandom_range(1, 2) + $urandom_range(0, 3);
			repeat (cells) send_cell(pick_density());
			sent += cells;
		end
	endtask

	task automatic test_quiet_tail();
		wait_drained();
		quiet = 1'b1;
		set_grid(11'd4, 11'd3);
		repeat (12) send_cell(pick_density());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_COLUMNS;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.density = '0;
		out_if.ready = 1'b1;
		stall_left = 0;
		quiet = 1'b0;
		fail_count = 0;
		cols_reg = GRID_RESET;
		rows_reg = GRID_RESET;
		cell_above = '0;
		cell_diag = '0;
		col_pos = 0;
		row_pos = 0;
		last_density = '0;
		foreach (line_store[i]) line_store[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_frame();
		test_saturation_and_zero_sum();
		test_size_extremes();
		test_random_frames();
		test_quiet_tail();
		wait_drained();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#30000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dvg_pkg.sv
hw/rtl/dvg_if.sv
hw/rtl/density_to_velocity_grid.sv
sim/tb_top.sv
